// ----- design/orm_pkg.sv -----
// ----------------------------------------------------------------------------
// orm_pkg
// Shared types and codes for the occupancy relay mode controller.
// ----------------------------------------------------------------------------
package orm_pkg;

    // Number of relays carried in state
    localparam int NUM_RELAYS = 2;

    // Register file
    localparam int CFG_ADDR_W = 4;
    localparam logic [CFG_ADDR_W-1:0] ADDR_LOCK_TIMEOUT = 4'h0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_OFF_DELAY    = 4'h4;
    localparam logic [CFG_ADDR_W-1:0] ADDR_EVAL_PERIOD  = 4'h8;

    localparam logic [31:0] RST_LOCK_TIMEOUT = 32'd300000;
    localparam logic [31:0] RST_OFF_DELAY    = 32'd30000;
    localparam logic [15:0] RST_EVAL_PERIOD  = 16'd100;

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_EVAL   = 2'd0,
        FUNC_TOGGLE = 2'd1,
        FUNC_MODE   = 2'd2,
        FUNC_REMOTE = 2'd3
    } func_t;

    // Relay modes
    typedef enum logic [1:0] {
        MODE_MANUAL      = 2'd0,
        MODE_PRESENCE    = 2'd1,
        MODE_AI          = 2'd2,
        MODE_AI_PRESENCE = 2'd3
    } mode_t;

    typedef struct packed {
        func_t       func;
        logic        channel;
        mode_t       new_mode;
        logic        want_on;
        logic        someone_present;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic        relay0_on;
        logic        relay1_on;
        mode_t       mode0;
        mode_t       mode1;
        logic [1:0]  locks;
        logic [1:0]  sessions;
        logic [1:0]  relay_changed;
    } out_t;

    // Configuration values seen by the core
    typedef struct packed {
        logic [31:0] lock_timeout_ms;
        logic [31:0] off_delay_ms;
        logic [15:0] eval_period_ms;
    } cfg_t;

endpackage

// ----- design/orm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// orm_cfg_regs
// APB-style register file: lock timeout, off delay, evaluation period.
// ----------------------------------------------------------------------------
module orm_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [orm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output orm_pkg::cfg_t                  cfg
);
    import orm_pkg::*;

    logic [31:0] lock_timeout_reg;
    logic [31:0] off_delay_reg;
    logic [15:0] eval_period_reg;
    logic        wr_en;
    logic [CFG_ADDR_W-1:0] addr_w;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    // word decode, byte lanes ignored
    assign addr_w = {paddr[CFG_ADDR_W-1:2], 2'b00};

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_timeout_reg <= RST_LOCK_TIMEOUT;
            off_delay_reg    <= RST_OFF_DELAY;
            eval_period_reg  <= RST_EVAL_PERIOD;
        end
        else if (wr_en)
        begin
            unique case (addr_w)
                ADDR_LOCK_TIMEOUT: lock_timeout_reg <= pwdata;
                ADDR_OFF_DELAY:    off_delay_reg    <= pwdata;
                ADDR_EVAL_PERIOD:  eval_period_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (addr_w)
            ADDR_LOCK_TIMEOUT: prdata = lock_timeout_reg;
            ADDR_OFF_DELAY:    prdata = off_delay_reg;
            ADDR_EVAL_PERIOD:  prdata = {16'd0, eval_period_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.lock_timeout_ms = lock_timeout_reg;
    assign cfg.off_delay_ms    = off_delay_reg;
    assign cfg.eval_period_ms  = eval_period_reg;

endmodule

// ----- design/orm_core.sv -----
// ----------------------------------------------------------------------------
// orm_core
// Relay, mode, lock and session state with the single-pass update logic.
// ----------------------------------------------------------------------------
module orm_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  orm_pkg::in_t  item,
    input  orm_pkg::cfg_t cfg,
    output orm_pkg::out_t result_next
);
    import orm_pkg::*;

    logic [NUM_RELAYS-1:0] relay_reg, relay_next;
    logic [NUM_RELAYS-1:0] lock_reg, lock_next;
    logic [NUM_RELAYS-1:0] session_reg, session_next;
    mode_t                 mode_reg [NUM_RELAYS];
    mode_t                 mode_next [NUM_RELAYS];
    logic [31:0]           lock_stamp_reg [NUM_RELAYS];
    logic [31:0]           lock_stamp_next [NUM_RELAYS];
    logic [31:0]           seen_reg [NUM_RELAYS];
    logic [31:0]           seen_next [NUM_RELAYS];
    logic [31:0]           last_eval_reg, last_eval_next;
    logic                  eval_go;

    assign eval_go = (item.func == FUNC_EVAL)
                  && ((item.now_ms - last_eval_reg) >= {16'd0, cfg.eval_period_ms});

    // next state for the current item
    always_comb
    begin
        logic sel;
        logic lk;
        logic present;
        present        = item.someone_present;
        relay_next     = relay_reg;
        lock_next      = lock_reg;
        session_next   = session_reg;
        mode_next      = mode_reg;
        lock_stamp_next = lock_stamp_reg;
        seen_next      = seen_reg;
        last_eval_next = eval_go ? item.now_ms : last_eval_reg;
        for (int i = 0; i < NUM_RELAYS; i++)
        begin
            sel = (int'(item.channel) == i);
            lk  = lock_reg[i];
            case (item.func)
                FUNC_EVAL:
                begin
                    if (eval_go)
                    begin
                        // lock expiry
                        lk = lock_reg[i]
                          && !((item.now_ms - lock_stamp_reg[i]) > cfg.lock_timeout_ms);
                        lock_next[i] = lk;
                        if (mode_reg[i] == MODE_PRESENCE || mode_reg[i] == MODE_AI_PRESENCE)
                        begin
                            if (present)
                            begin
                                // new session; plain presence mode drops the lock
                                if (!session_reg[i])
                                begin
                                    if (mode_reg[i] == MODE_PRESENCE)
                                        lk = 1'b0;
                                    session_next[i] = 1'b1;
                                end
                                lock_next[i] = lk;
                                seen_next[i] = item.now_ms;
                                if (!lk)
                                    relay_next[i] = 1'b1;
                            end
                            else if (session_reg[i]
                                  && ((item.now_ms - seen_reg[i]) > cfg.off_delay_ms))
                            begin
                                session_next[i] = 1'b0;
                                if (!lk)
                                    relay_next[i] = 1'b0;
                            end
                        end
                        else
                        begin
                            session_next[i] = present;
                        end
                    end
                end
                FUNC_TOGGLE:
                begin
                    if (sel)
                    begin
                        lock_next[i]       = 1'b1;
                        lock_stamp_next[i] = item.now_ms;
                        relay_next[i]      = !relay_reg[i];
                    end
                end
                FUNC_MODE:
                begin
                    if (sel && (mode_reg[i] != item.new_mode))
                    begin
                        mode_next[i]    = item.new_mode;
                        lock_next[i]    = 1'b0;
                        session_next[i] = 1'b0;
                        seen_next[i]    = 32'd0;
                        if (present && (item.new_mode == MODE_PRESENCE
                                     || item.new_mode == MODE_AI_PRESENCE))
                            relay_next[i] = 1'b1;
                    end
                end
                default:
                begin
                    if (sel)
                        relay_next[i] = item.want_on;
                end
            endcase
        end
    end

    // result fields: relays zero and one only
    always_comb
    begin
        logic [1:0] rl;
        logic [1:0] lk2;
        logic [1:0] ss;
        logic [1:0] ch;
        mode_t      md [2];
        rl  = 2'b00;
        lk2 = 2'b00;
        ss  = 2'b00;
        ch  = 2'b00;
        md[0] = MODE_MANUAL;
        md[1] = MODE_MANUAL;
        for (int i = 0; i < 2; i++)
        begin
            if (i < NUM_RELAYS)
            begin
                rl[i]  = relay_next[i];
                lk2[i] = lock_next[i];
                ss[i]  = session_next[i];
                ch[i]  = relay_next[i] ^ relay_reg[i];
                md[i]  = mode_next[i];
            end
        end
        result_next.relay0_on     = rl[0];
        result_next.relay1_on     = rl[1];
        result_next.mode0         = md[0];
        result_next.mode1         = md[1];
        result_next.locks         = lk2;
        result_next.sessions      = ss;
        result_next.relay_changed = ch;
    end

    // state registers, updated when the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg     <= '0;
            lock_reg      <= '0;
            session_reg   <= '0;
            last_eval_reg <= 32'd0;
            for (int i = 0; i < NUM_RELAYS; i++)
            begin
                mode_reg[i]       <= MODE_MANUAL;
                lock_stamp_reg[i] <= 32'd0;
                seen_reg[i]       <= 32'd0;
            end
        end
        else if (fire)
        begin
            relay_reg      <= relay_next;
            lock_reg       <= lock_next;
            session_reg    <= session_next;
            last_eval_reg  <= last_eval_next;
            mode_reg       <= mode_next;
            lock_stamp_reg <= lock_stamp_next;
            seen_reg       <= seen_next;
        end
    end

`ifndef NO_ASSERTIONS
    // toggle on relay zero always leaves its lock set
    a_toggle_locks: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.func == FUNC_TOGGLE && item.channel == 1'b0 |=> lock_reg[0])
        else $error("toggle did not take the lock");

    // state holds while no item is processed
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(relay_reg) && $stable(lock_reg) && $stable(session_reg))
        else $error("state changed without an item");

    // an evaluation that runs records its time stamp
    a_eval_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eval_go |=> last_eval_reg == $past(item.now_ms))
        else $error("evaluation stamp not recorded");

    // a mode change on relay zero clears its lock and session
    a_mode_unlock: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.func == FUNC_MODE && item.channel == 1'b0
        && mode_reg[0] != item.new_mode |=> !lock_reg[0] && !session_reg[0])
        else $error("mode change kept lock or session");
`endif

endmodule

// ----- design/occupancy_relay_mode_controller.sv -----
// ----------------------------------------------------------------------------
// occupancy_relay_mode_controller
// Two-relay occupancy controller: toggles, mode sets, remote sets and
// periodic presence evaluation with lock timeout and off delay.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        sink       in_valid / in_stall     in_data  (orm_pkg::in_t)
//  out       source     out_valid / out_stall   out_data (orm_pkg::out_t)
//  cfg       APB slave  psel/penable/pready     paddr, pwdata, prdata
//
// One request per cycle sustained while the output is not stalled; each passes
// from acceptance to result through an input register, one pass of update logic and a result register.
// State is written when a request moves into the result register.
// An output stall holds the result; one more request is taken into the input
// register behind it, then in_stall rises.
// Reset (rst_n low) clears relays, modes, locks, sessions and stamps.
// ----------------------------------------------------------------------------
module occupancy_relay_mode_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  orm_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output orm_pkg::out_t                  out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [orm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import orm_pkg::*;

    cfg_t  cfg;
    in_t   item_reg;
    logic  item_valid_reg;
    out_t  result_reg;
    out_t  result_next;
    logic  out_valid_reg;
    logic  advance;
    logic  fire;
    logic  take;

    orm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline control
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = item_valid_reg && advance;
    assign in_stall = item_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    orm_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= item_valid_reg;
            if (!in_stall)
                item_valid_reg <= in_valid;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= in_data;
        if (fire)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

endmodule
